FILE: hw/rtl/ple_pkg.sv
// ple_pkg: shared widths, command kinds, status codes and default sizes
// for the positional list engine
// no dependencies
package ple_pkg;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    // default sizing
    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // command kinds
    localparam logic [KIND_W-1:0] KIND_APPEND      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT_AT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE_LAST = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE_AT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ_AT     = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

FILE: hw/rtl/ple_cmd_if.sv
// ple_cmd_if: command channel of the positional list engine (valid/ready)
// depends on ple_pkg
interface ple_cmd_if #(
    parameter int ELEMENT_WIDTH = ple_pkg::ELEMENT_WIDTH_DEF
);
    import ple_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic [ELEMENT_WIDTH-1:0] element;

    modport source (output valid, kind, position, element, input ready);
    modport sink   (input valid, kind, position, element, output ready);
endinterface

FILE: hw/rtl/ple_rsp_if.sv
// ple_rsp_if: result channel of the positional list engine (valid/ready)
// depends on ple_pkg
interface ple_rsp_if #(
    parameter int CAPACITY      = ple_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ple_pkg::ELEMENT_WIDTH_DEF
);
    import ple_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [ELEMENT_WIDTH-1:0] element_out;
    logic [COUNT_W-1:0]       entry_count;
    logic [ELEMENT_WIDTH-1:0] first_element;
    logic [ELEMENT_WIDTH-1:0] last_element;

    modport source (output valid, status, element_out, entry_count, first_element,
                    last_element, input ready);
    modport sink   (input valid, status, element_out, entry_count, first_element,
                    last_element, output ready);
endinterface

FILE: hw/rtl/positional_list_engine.sv
// positional_list_engine: bounded ordered list with positional insert,
// remove and read, run by a small sequencer over one entry memory
// depends on ple_pkg, ple_cmd_if, ple_rsp_if, ple_entry_ram
//
// Usage:
//   cmd carries one command word (kind, position, element); rsp returns one
//   result word per command (status, element_out, entry_count, first and
//   last element). Both channels transfer on valid and ready high together.
//   The block handles one command at a time: cmd.ready is high only while
//   the sequencer is idle.
//   Sequence: append, full, empty and unused kinds go straight to the head
//   and tail fetch, then the output load; read and remove first capture the
//   entry. Insert at index p moves each entry at or above p up one place;
//   removal at index p moves each entry above p down one place. Each move
//   costs a read then a write of the single entry memory. After the output
//   load the sequencer returns to idle before the next command is taken.
//   Reset empties the list at once (count to zero); the memory contents are
//   not cleared and no entry beyond the count is ever returned.
//   The result word sits in an output register: a new command is accepted
//   while it waits, and the sequencer only stalls when a second result is
//   ready before the first has been taken.
module positional_list_engine #(
    parameter int CAPACITY      = ple_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = ple_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ple_cmd_if.sink   cmd,
    ple_rsp_if.source rsp
);
    import ple_pkg::*;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_GRAB  = 9'b000000010,
        S_UP_RD = 9'b000000100,
        S_UP_WR = 9'b000001000,
        S_PUT   = 9'b000010000,
        S_DN_RD = 9'b000100000,
        S_DN_WR = 9'b001000000,
        S_ENDS  = 9'b010000000,
        S_LOAD  = 9'b100000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [COUNT_W-1:0]       occ_reg, occ_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic [KIND_W-1:0]        kind_reg, kind_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ELEMENT_WIDTH-1:0] elem_reg, elem_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [ELEMENT_WIDTH-1:0] got_reg, got_next;

    logic [STATUS_W-1:0]      rsp_status_reg, rsp_status_next;
    logic [ELEMENT_WIDTH-1:0] rsp_elem_reg, rsp_elem_next;
    logic [COUNT_W-1:0]       rsp_count_reg, rsp_count_next;
    logic [ELEMENT_WIDTH-1:0] rsp_first_reg, rsp_first_next;
    logic [ELEMENT_WIDTH-1:0] rsp_last_reg, rsp_last_next;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic [ELEMENT_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
    logic [ELEMENT_WIDTH-1:0] rdata_a;
    logic [ELEMENT_WIDTH-1:0] rdata_b;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic [ADDR_W-1:0]        last_idx;
    logic [ADDR_W-1:0]        occ_idx;
    logic [ADDR_W-1:0]        cmd_pos_idx;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         occ_ext;
    logic [CMP_W-1:0]         occ_m1_ext;

    // entry store
    ple_entry_ram #(
        .DEPTH  (CAPACITY),
        .WIDTH  (ELEMENT_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // handshake and list bounds
    assign cmd.ready   = (state_reg == S_IDLE);
    assign accept      = cmd.valid && (state_reg == S_IDLE);
    assign full        = (occ_reg == COUNT_W'(CAPACITY));
    assign empty       = (occ_reg == '0);
    assign last_idx    = ADDR_W'(occ_reg - COUNT_W'(1));
    assign occ_idx     = ADDR_W'(occ_reg);
    assign cmd_pos_idx = ADDR_W'(cmd.position);
    assign pos_ext     = CMP_W'(cmd.position);
    assign occ_ext     = CMP_W'(occ_reg);
    assign occ_m1_ext  = occ_ext - CMP_W'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        kind_next       = kind_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        elem_next       = elem_reg;
        status_next     = status_reg;
        got_next        = got_reg;
        rsp_status_next = rsp_status_reg;
        rsp_elem_next   = rsp_elem_reg;
        rsp_count_next  = rsp_count_reg;
        rsp_first_next  = rsp_first_reg;
        rsp_last_next   = rsp_last_reg;
        we              = 1'b0;
        waddr           = idx_reg;
        wdata           = rdata_a;
        raddr_a         = '0;
        raddr_b         = last_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next   = cmd.kind;
                    elem_next   = cmd.element;
                    status_next = ST_OK;
                    got_next    = '0;
                    state_next  = S_ENDS;
                    case (cmd.kind)
                        KIND_APPEND, KIND_INSERT_AT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (cmd.kind == KIND_APPEND || pos_ext >= occ_ext)
                            begin
                                // tail append
                                we       = 1'b1;
                                waddr    = occ_idx;
                                wdata    = cmd.element;
                                occ_next = occ_reg + COUNT_W'(1);
                            end
                            else
                            begin
                                // open a gap at the position, top entry first
                                pos_next   = cmd_pos_idx;
                                idx_next   = occ_idx;
                                state_next = S_UP_RD;
                            end
                        end
                        KIND_REMOVE_LAST, KIND_REMOVE_AT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (cmd.kind == KIND_REMOVE_LAST || pos_ext >= occ_m1_ext)
                            begin
                                raddr_a    = last_idx;
                                pos_next   = last_idx;
                                state_next = S_GRAB;
                            end
                            else
                            begin
                                raddr_a    = cmd_pos_idx;
                                pos_next   = cmd_pos_idx;
                                state_next = S_GRAB;
                            end
                        end
                        KIND_READ_AT:
                        begin
                            if (pos_ext >= occ_ext)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                raddr_a    = cmd_pos_idx;
                                pos_next   = cmd_pos_idx;
                                state_next = S_GRAB;
                            end
                        end
                        default:
                        begin
                            state_next = S_ENDS;
                        end
                    endcase
                end
            end

            // capture the read or removed entry
            S_GRAB:
            begin
                got_next = rdata_a;
                if (kind_reg == KIND_READ_AT)
                begin
                    state_next = S_ENDS;
                end
                else if (pos_reg == last_idx)
                begin
                    occ_next   = occ_reg - COUNT_W'(1);
                    state_next = S_ENDS;
                end
                else
                begin
                    idx_next   = pos_reg;
                    state_next = S_DN_RD;
                end
            end

            // move entry idx-1 up to idx
            S_UP_RD:
            begin
                raddr_a    = idx_reg - ADDR_W'(1);
                state_next = S_UP_WR;
            end

            S_UP_WR:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = rdata_a;
                idx_next = idx_reg - ADDR_W'(1);
                if (idx_reg - ADDR_W'(1) == pos_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_UP_RD;
                end
            end

            // drop the new element into the gap
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = pos_reg;
                wdata      = elem_reg;
                occ_next   = occ_reg + COUNT_W'(1);
                state_next = S_ENDS;
            end

            // move entry idx+1 down to idx
            S_DN_RD:
            begin
                raddr_a    = idx_reg + ADDR_W'(1);
                state_next = S_DN_WR;
            end

            S_DN_WR:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = rdata_a;
                idx_next = idx_reg + ADDR_W'(1);
                if (idx_reg + ADDR_W'(1) == last_idx)
                begin
                    occ_next   = occ_reg - COUNT_W'(1);
                    state_next = S_ENDS;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            // fetch head and tail entries
            S_ENDS:
            begin
                state_next = S_LOAD;
            end

            // fill the output register once it is free
            S_LOAD:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_elem_next   = got_reg;
                    rsp_count_next  = occ_reg;
                    rsp_first_next  = empty ? '0 : rdata_a;
                    rsp_last_next   = empty ? '0 : rdata_b;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        elem_reg       <= elem_next;
        status_reg     <= status_next;
        got_reg        <= got_next;
        rsp_status_reg <= rsp_status_next;
        rsp_elem_reg   <= rsp_elem_next;
        rsp_count_reg  <= rsp_count_next;
        rsp_first_reg  <= rsp_first_next;
        rsp_last_reg   <= rsp_last_next;
    end

    // result channel
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.element_out   = rsp_elem_reg;
    assign rsp.entry_count   = rsp_count_reg;
    assign rsp.first_element = rsp_first_reg;
    assign rsp.last_element  = rsp_last_reg;

endmodule

FILE: hw/rtl/ple_entry_ram.sv
// ple_entry_ram: entry store, one write port and two registered read ports
// depends on nothing beyond its parameters
module ple_entry_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
